/* src/enuad_pkg.sv */
// ----------------------------------------------------------------------------
// enuad_pkg
// Shared constants and types for the geodetic ENU basis and magnitude block.
// ----------------------------------------------------------------------------
package enuad_pkg;

  localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE_HALF_Q60 = 64'h1800_0000_0000_0000;
  localparam logic [63:0] THREE_Q60    = 64'h3000_0000_0000_0000;
  localparam logic [63:0] PIQ60        = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] EIGHTH_TURN  = 64'h2000_0000_0000_0000;
  localparam logic [33:0] MAG_MAX      = 34'h3_FFFF_FFFF;

  localparam int SERIES_TERMS = 11;
  localparam int NEWTON_STEPS = 10;
  localparam int MUL_LAT      = 2;
  localparam int TRIG_MULS    = 3 + 2 * SERIES_TERMS;

  // horner divisors, highest term first
  localparam int unsigned SIN_DIV [SERIES_TERMS] =
    '{506, 420, 342, 272, 210, 156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [SERIES_TERMS] =
    '{462, 380, 306, 240, 182, 132, 90, 56, 30, 12, 2};

  localparam logic [1:0] REG_SEMI_MAJOR = 2'd0;
  localparam logic [1:0] REG_FLATTENING = 2'd1;

  localparam logic [32:0] SEMI_MAJOR_RESET = 33'd6378137000;
  localparam logic [38:0] FLATTENING_RESET = 39'd3686454312;

  typedef struct packed {
    logic [63:0] sm;
    logic        sn;
    logic [63:0] cm;
    logic        cn;
  } trig_t;

endpackage

/* src/enuad_mul.sv */
// ----------------------------------------------------------------------------
// enuad_mul
// Two-stage 64x64 multiply, four 32x32 partial products then sum and shift,
// with a side bus delayed alongside.
// ----------------------------------------------------------------------------
module enuad_mul #(
  parameter int SHIFT = 60,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  input  logic [SW-1:0] side_in,
  output logic [63:0]   p,
  output logic [SW-1:0] side_out
);

  logic [63:0]   pp00, pp01, pp10, pp11;
  logic [SW-1:0] side_mid;
  logic [127:0]  full;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00     <= 64'(a[31:0]) * 64'(b[31:0]);
      pp01     <= 64'(a[31:0]) * 64'(b[63:32]);
      pp10     <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11     <= 64'(a[63:32]) * 64'(b[63:32]);
      side_mid <= side_in;
    end
  end

  always_comb begin
    full = {pp11, 64'd0} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0} + {64'd0, pp00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p        <= 64'(full >> SHIFT);
      side_out <= side_mid;
    end
  end

endmodule

/* src/enuad_trig.sv */
// ----------------------------------------------------------------------------
// enuad_trig
// Pipelined sine and cosine of a 64-bit binary angle: octant reduction,
// Horner series in Q60 with reciprocal divides, octant symmetry.
// ----------------------------------------------------------------------------
module enuad_trig #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       w,
  input  logic [SW-1:0]     side_in,
  output enuad_pkg::trig_t  res,
  output logic [SW-1:0]     side_out
);

  localparam int N = enuad_pkg::SERIES_TERMS;

  logic [2:0]    oct;
  logic [63:0]   r;
  logic [63:0]   x;
  logic [2+SW:0] hd1;

  logic [63:0]   x_s   [0:N];
  logic [63:0]   x2_s  [0:N];
  logic [63:0]   s_s   [0:N];
  logic [63:0]   c_s   [0:N];
  logic [2:0]    oct_s [0:N];
  logic [SW-1:0] side_s [0:N];

  logic [63:0]   sv, cv;
  logic [2:0]    oct_f, oct_p1, oct_p2;

  always_comb begin
    oct = w[63:61];
    r   = {3'd0, w[60:0]};
    if (oct[0]) begin
      r = enuad_pkg::EIGHTH_TURN - r;
    end
  end

  enuad_mul #(.SHIFT(63), .SW(3 + SW)) u_x (
    .clk, .en, .a(r), .b(enuad_pkg::PIQ60),
    .side_in({oct, side_in}), .p(x), .side_out(hd1)
  );

  enuad_mul #(.SHIFT(60), .SW(67 + SW)) u_x2 (
    .clk, .en, .a(x), .b(x),
    .side_in({x, hd1}), .p(x2_s[0]), .side_out({x_s[0], oct_s[0], side_s[0]})
  );

  assign s_s[0] = enuad_pkg::ONE_Q60;
  assign c_s[0] = enuad_pkg::ONE_Q60;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int unsigned DS = enuad_pkg::SIN_DIV[i];
    localparam int unsigned DC = enuad_pkg::COS_DIV[i];
    localparam int KS = 60 + $clog2(DS);
    localparam int KC = 60 + $clog2(DC);
    localparam logic [63:0] MS = 64'(((128'd1 << KS) + 128'(DS) - 128'd1) / 128'(DS));
    localparam logic [63:0] MC = 64'(((128'd1 << KC) + 128'(DC) - 128'd1) / 128'(DC));

    logic [63:0]   ps, pc, qs, qc;
    logic [127:0]  sa;
    logic [2+SW:0] ca;

    enuad_mul #(.SHIFT(60), .SW(128)) u_ps (
      .clk, .en, .a(x2_s[i]), .b(s_s[i]),
      .side_in({x2_s[i], x_s[i]}), .p(ps), .side_out(sa)
    );
    enuad_mul #(.SHIFT(60), .SW(3 + SW)) u_pc (
      .clk, .en, .a(x2_s[i]), .b(c_s[i]),
      .side_in({oct_s[i], side_s[i]}), .p(pc), .side_out(ca)
    );
    enuad_mul #(.SHIFT(KS), .SW(128)) u_qs (
      .clk, .en, .a(ps), .b(MS),
      .side_in(sa), .p(qs), .side_out({x2_s[i+1], x_s[i+1]})
    );
    enuad_mul #(.SHIFT(KC), .SW(3 + SW)) u_qc (
      .clk, .en, .a(pc), .b(MC),
      .side_in(ca), .p(qc), .side_out({oct_s[i+1], side_s[i+1]})
    );

    assign s_s[i+1] = enuad_pkg::ONE_Q60 - qs;
    assign c_s[i+1] = enuad_pkg::ONE_Q60 - qc;
  end

  enuad_mul #(.SHIFT(60), .SW(67 + SW)) u_sv (
    .clk, .en, .a(x_s[N]), .b(s_s[N]),
    .side_in({c_s[N], oct_s[N], side_s[N]}), .p(sv), .side_out({cv, oct_f, side_out})
  );

  always_comb begin
    oct_p1 = oct_f + 3'd1;
    oct_p2 = oct_f + 3'd2;
    if (oct_p1[1]) begin
      res.sm = cv;
      res.cm = sv;
    end else begin
      res.sm = sv;
      res.cm = cv;
    end
    res.sn = oct_f[2];
    res.cn = oct_p2[2];
  end

endmodule

/* src/enu_axis_directions_magnitudes_core.sv */
// ----------------------------------------------------------------------------
// enu_axis_directions_magnitudes_core
// Geodetic point to unit East, North, Up vectors and the East and North
// derivative magnitudes on a configurable ellipsoid.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls (a held result with
//   out_ready low freezes the whole pipeline); the depth is set by the chain
//   of 60 dependent 64x64 multiplies (series trig, Newton inverse root), each
//   registered as four 32x32 partial products and then a sum
// reset: clears all valid bits and loads the WGS-84 axis and flattening
// ----------------------------------------------------------------------------
module enu_axis_directions_magnitudes_core #(
  parameter int ANGLE_BITS = 32,
  parameter int DIR_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [38:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ANGLE_BITS-1:0]  latitude,
  input  logic signed [ANGLE_BITS-1:0]  longitude,
  input  logic signed [27:0]            height_mm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DIR_FRAC_BITS+1:0] east_x,
  output logic signed [DIR_FRAC_BITS+1:0] east_y,
  output logic signed [DIR_FRAC_BITS+1:0] east_z,
  output logic signed [DIR_FRAC_BITS+1:0] north_x,
  output logic signed [DIR_FRAC_BITS+1:0] north_y,
  output logic signed [DIR_FRAC_BITS+1:0] north_z,
  output logic signed [DIR_FRAC_BITS+1:0] up_x,
  output logic signed [DIR_FRAC_BITS+1:0] up_y,
  output logic signed [DIR_FRAC_BITS+1:0] up_z,
  output logic [33:0]                   east_magnitude_mm,
  output logic [33:0]                   north_magnitude_mm
);

  localparam int DW  = DIR_FRAC_BITS + 2;
  localparam int TW  = 8 * DW + 92;
  localparam int NS  = enuad_pkg::NEWTON_STEPS;
  localparam int LAT = enuad_pkg::MUL_LAT * (enuad_pkg::TRIG_MULS + 5 + 3 * NS) + 1;
  localparam logic signed [DW-1:0] UNIT_POS = DW'(64'd1 << DIR_FRAC_BITS);
  localparam logic signed [DW-1:0] UNIT_NEG = -UNIT_POS;

  function automatic logic [DW-1:0] comp(input logic [63:0] mag, input logic neg);
    logic [63:0] v;
    v = (mag + (64'd1 << (59 - DIR_FRAC_BITS))) >> (60 - DIR_FRAC_BITS);
    return neg ? DW'(64'd0 - v) : DW'(v);
  endfunction

  function automatic logic [63:0] abs_sum(input logic [63:0] rad, input logic [63:0] hq);
    logic [63:0] t;
    t = rad + hq;
    return t[63] ? 64'd0 - t : t;
  endfunction

  function automatic logic [63:0] h_q24(input logic [27:0] h);
    return {{12{h[27]}}, h, 24'd0};
  endfunction

  function automatic logic [33:0] mag_mm(input logic [63:0] q);
    logic [40:0] v;
    v = {1'b0, q[63:24]} + 41'(q[23]);
    return (v > 41'(enuad_pkg::MAG_MAX)) ? enuad_pkg::MAG_MAX : v[33:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  logic [32:0] semi_major_axis_mm;
  logic [38:0] flattening_q40;
  logic [63:0] omf, ome2, e2;
  logic [32:0] semi_major_d;

  enuad_pkg::trig_t lat_t, lon_t;
  logic [13:0] h_hi_t, h_lo_t;

  logic [63:0]     p_sc, p_ss, p_cc, p_cs, p_sp2, cp_d;
  logic [3:0]      sg_d;
  logic [2*DW-1:0] exy_d, nzuz_d;
  logic [27:0]     h_d;
  logic [TW-1:0]   tail0, tail_w;
  logic [63:0]     ew;

  logic [63:0]   y_n    [0:NS];
  logic [63:0]   w_n    [0:NS];
  logic [TW-1:0] tail_n [0:NS];

  logic [8*DW-1:0] dirs_f, dirs_a, dirs_b, dirs_c;
  logic [91:0]     cph_a;
  logic [63:0]     r2, nq, am, eq, mq24, r2_b, eq_c;
  logic [27:0]     h_b, h_c;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major_axis_mm <= enuad_pkg::SEMI_MAJOR_RESET;
      flattening_q40     <= enuad_pkg::FLATTENING_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        enuad_pkg::REG_SEMI_MAJOR: semi_major_axis_mm <= cfg_data[32:0];
        enuad_pkg::REG_FLATTENING: flattening_q40 <= cfg_data;
        default: ;
      endcase
    end
  end

  // ellipsoid terms follow the registers continuously
  assign omf = enuad_pkg::ONE_Q60 - {5'd0, flattening_q40, 20'd0};

  enuad_mul #(.SHIFT(60), .SW(33)) u_ome2 (
    .clk, .en(1'b1), .a(omf), .b(omf),
    .side_in(semi_major_axis_mm), .p(ome2), .side_out(semi_major_d)
  );

  assign e2 = enuad_pkg::ONE_Q60 - ome2;

  enuad_trig #(.SW(14)) u_lat (
    .clk, .en, .w(64'({latitude, {(64 - ANGLE_BITS){1'b0}}})),
    .side_in(height_mm[27:14]), .res(lat_t), .side_out(h_hi_t)
  );

  enuad_trig #(.SW(14)) u_lon (
    .clk, .en, .w(64'({longitude, {(64 - ANGLE_BITS){1'b0}}})),
    .side_in(height_mm[13:0]), .res(lon_t), .side_out(h_lo_t)
  );

  enuad_mul #(.SHIFT(60), .SW(4)) u_sc (
    .clk, .en, .a(lat_t.sm), .b(lon_t.cm),
    .side_in({!(lat_t.sn != lon_t.cn), !(lat_t.sn != lon_t.sn),
              lat_t.cn != lon_t.cn, lat_t.cn != lon_t.sn}),
    .p(p_sc), .side_out(sg_d)
  );

  enuad_mul #(.SHIFT(60), .SW(2 * DW)) u_ss (
    .clk, .en, .a(lat_t.sm), .b(lon_t.sm),
    .side_in({comp(lon_t.sm, !lon_t.sn), comp(lon_t.cm, lon_t.cn)}),
    .p(p_ss), .side_out(exy_d)
  );

  enuad_mul #(.SHIFT(60), .SW(2 * DW)) u_cc (
    .clk, .en, .a(lat_t.cm), .b(lon_t.cm),
    .side_in({comp(lat_t.cm, lat_t.cn), comp(lat_t.sm, lat_t.sn)}),
    .p(p_cc), .side_out(nzuz_d)
  );

  enuad_mul #(.SHIFT(60), .SW(64)) u_cs (
    .clk, .en, .a(lat_t.cm), .b(lon_t.sm),
    .side_in(lat_t.cm), .p(p_cs), .side_out(cp_d)
  );

  enuad_mul #(.SHIFT(60), .SW(28)) u_sp2 (
    .clk, .en, .a(lat_t.sm), .b(lat_t.sm),
    .side_in({h_hi_t, h_lo_t}), .p(p_sp2), .side_out(h_d)
  );

  assign tail0 = {exy_d, comp(p_sc, sg_d[3]), comp(p_ss, sg_d[2]), nzuz_d[2*DW-1:DW],
                  comp(p_cc, sg_d[1]), comp(p_cs, sg_d[0]), nzuz_d[DW-1:0], cp_d, h_d};

  enuad_mul #(.SHIFT(60), .SW(TW)) u_w (
    .clk, .en, .a(e2), .b(p_sp2),
    .side_in(tail0), .p(ew), .side_out(tail_w)
  );

  assign w_n[0]    = enuad_pkg::ONE_Q60 - ew;
  assign y_n[0]    = enuad_pkg::ONE_HALF_Q60 - (w_n[0] >> 1);
  assign tail_n[0] = tail_w;

  for (genvar j = 0; j < NS; j++) begin : g_newton
    logic [63:0]     yy, v;
    logic [TW+127:0] b1, b2;

    enuad_mul #(.SHIFT(60), .SW(TW + 128)) u_yy (
      .clk, .en, .a(y_n[j]), .b(y_n[j]),
      .side_in({y_n[j], w_n[j], tail_n[j]}), .p(yy), .side_out(b1)
    );
    enuad_mul #(.SHIFT(60), .SW(TW + 128)) u_v (
      .clk, .en, .a(b1[TW+63:TW]), .b(yy),
      .side_in(b1), .p(v), .side_out(b2)
    );
    enuad_mul #(.SHIFT(61), .SW(TW + 64)) u_y (
      .clk, .en, .a(b2[TW+127:TW+64]), .b(enuad_pkg::THREE_Q60 - v),
      .side_in(b2[TW+63:0]), .p(y_n[j+1]), .side_out({w_n[j+1], tail_n[j+1]})
    );
  end

  assign dirs_f = tail_n[NS][TW-1:92];

  enuad_mul #(.SHIFT(60), .SW(8 * DW)) u_r2 (
    .clk, .en, .a(y_n[NS]), .b(y_n[NS]),
    .side_in(dirs_f), .p(r2), .side_out(dirs_a)
  );

  enuad_mul #(.SHIFT(36), .SW(92)) u_nq (
    .clk, .en, .a({31'd0, semi_major_d}), .b(y_n[NS]),
    .side_in(tail_n[NS][91:0]), .p(nq), .side_out(cph_a)
  );

  enuad_mul #(.SHIFT(60), .SW(92)) u_am (
    .clk, .en, .a(nq), .b(ome2),
    .side_in({r2, cph_a[27:0]}), .p(am), .side_out({r2_b, h_b})
  );

  enuad_mul #(.SHIFT(60), .SW(8 * DW)) u_eq (
    .clk, .en, .a(abs_sum(nq, h_q24(cph_a[27:0]))), .b(cph_a[91:28]),
    .side_in(dirs_a), .p(eq), .side_out(dirs_b)
  );

  enuad_mul #(.SHIFT(60), .SW(8 * DW + 92)) u_mq (
    .clk, .en, .a(am), .b(r2_b),
    .side_in({eq, dirs_b, h_b}), .p(mq24), .side_out({eq_c, dirs_c, h_c})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      east_x             <= dirs_c[8*DW-1:7*DW];
      east_y             <= dirs_c[7*DW-1:6*DW];
      north_x            <= dirs_c[6*DW-1:5*DW];
      north_y            <= dirs_c[5*DW-1:4*DW];
      north_z            <= dirs_c[4*DW-1:3*DW];
      up_x               <= dirs_c[3*DW-1:2*DW];
      up_y               <= dirs_c[2*DW-1:DW];
      up_z               <= dirs_c[DW-1:0];
      east_magnitude_mm  <= mag_mm(eq_c);
      north_magnitude_mm <= mag_mm(abs_sum(mq24, h_q24(h_c)));
    end
  end

  assign east_z = '0;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("valid chain moved during stall");

  a_up_z_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (up_z <= UNIT_POS) && (up_z >= UNIT_NEG))
    else $error("up_z beyond unit length");

  a_north_z_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (north_z <= UNIT_POS) && (north_z >= UNIT_NEG))
    else $error("north_z beyond unit length");

endmodule
